// ----- sv/slpg_pkg.sv -----
`timescale 1ns / 1ps

package slpg_pkg;

  // Widths of the time base and of the fields
  localparam int TIME_BITS = 32;
  localparam int CNT_W     = $clog2(TIME_BITS);
  localparam int CFG_W     = 10;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int COLOR_W   = 8;
  localparam int PERIOD_W  = 12;
  localparam int HALF_W    = PERIOD_W - 1;
  localparam int NUM_W     = 19;
  localparam int PROD_W    = 2 * COLOR_W;
  localparam int DIV_STEPS = 8;
  localparam int DIV_BIT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0]   INTERVAL_RESET = CFG_W'(20);
  localparam logic [COLOR_W-1:0] FLOOR_LEVEL    = COLOR_W'(25);
  localparam logic [COLOR_W-1:0] SPAN_LEVEL     = COLOR_W'(230);
  localparam logic [COLOR_W-1:0] FULL_LEVEL     = COLOR_W'(255);

  // Input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_OFF  = 2'd2
  } op_e;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INIT   = 3'd0,
    ST_NORMAL = 3'd1,
    ST_WARN   = 3'd2,
    ST_ERROR  = 3'd3,
    ST_CALIB  = 3'd4
  } status_e;

  typedef struct packed {
    logic [COLOR_W-1:0]  r;
    logic [COLOR_W-1:0]  g;
    logic [COLOR_W-1:0]  b;
    logic [PERIOD_W-1:0] period;
    logic                breathe;
  } look_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 tick;
    logic                 set_status;
    logic                 start_mod;
    logic                 mod_step;
    logic                 scale;
    logic                 div_step;
    logic [DIV_BIT_W-1:0] div_bit;
    logic                 blink_level;
    logic                 breathe_level;
    logic                 mul;
    logic                 load_out;
    logic                 load_off;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic refresh_due;
    logic breathe;
    logic out_busy;
  } dp_stat_t;

  // Color, period and style of each status
  function automatic look_t look_of(logic [STATUS_W-1:0] st);
    look_t lk;
    case (status_e'(st))
      ST_NORMAL: lk = '{r: 8'd0,   g: 8'd255, b: 8'd0,   period: 12'd3000, breathe: 1'b1};
      ST_WARN:   lk = '{r: 8'd255, g: 8'd140, b: 8'd0,   period: 12'd900,  breathe: 1'b0};
      ST_ERROR:  lk = '{r: 8'd255, g: 8'd0,   b: 8'd0,   period: 12'd250,  breathe: 1'b0};
      ST_CALIB:  lk = '{r: 8'd255, g: 8'd0,   b: 8'd200, period: 12'd500,  breathe: 1'b1};
      default:   lk = '{r: 8'd0,   g: 8'd40,  b: 8'd255, period: 12'd600,  breathe: 1'b1};
    endcase
    return lk;
  endfunction

  // x / 255 for x up to 255 * 255, by reciprocal with correction
  function automatic logic [COLOR_W-1:0] div255(logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {{(COLOR_W + 1){1'b0}}, x[PROD_W-1:COLOR_W]} + (PROD_W + 1)'(1);
    return t[PROD_W-1:COLOR_W];
  endfunction

endpackage

// ----- sv/slpg_in_if.sv -----
`timescale 1ns / 1ps

interface slpg_in_if;
  logic                          valid;
  logic                          ready;
  logic [slpg_pkg::OP_W-1:0]     op;
  logic [slpg_pkg::STATUS_W-1:0] new_status;

  modport source (output valid, output op, output new_status, input ready);
  modport sink (input valid, input op, input new_status, output ready);
endinterface

// ----- sv/slpg_out_if.sv -----
`timescale 1ns / 1ps

interface slpg_out_if;
  logic                          valid;
  logic                          ready;
  logic [slpg_pkg::COLOR_W-1:0]  red;
  logic [slpg_pkg::COLOR_W-1:0]  green;
  logic [slpg_pkg::COLOR_W-1:0]  blue;
  logic [slpg_pkg::STATUS_W-1:0] shown_status;

  modport source (output valid, output red, output green, output blue,
                  output shown_status, input ready);
  modport sink (input valid, input red, input green, input blue,
                input shown_status, output ready);
endinterface

// ----- sv/slpg_ctrl.sv -----
`timescale 1ns / 1ps

module slpg_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [slpg_pkg::OP_W-1:0]   in_op_i,
  output logic                        in_ready_o,
  input  slpg_pkg::dp_stat_t          stat_i,
  output slpg_pkg::dp_cmd_t           cmd_o
);
  import slpg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TEST  = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_LEVEL = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_FLOOR = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_OFF   = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    cmd_o.div_bit = cnt_q[DIV_BIT_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(in_op_i))
            OP_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = S_TEST;
            end
            OP_SET: cmd_o.set_status = 1'b1;
            OP_OFF: state_d = S_OFF;
            default: ;
          endcase
        end
      end
      S_TEST: begin
        if (stat_i.refresh_due) begin
          cmd_o.start_mod = 1'b1;
          cnt_d           = CNT_W'(TIME_BITS - 1);
          state_d         = S_MOD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_LEVEL;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_LEVEL: begin
        if (stat_i.breathe) begin
          cmd_o.scale = 1'b1;
          cnt_d       = CNT_W'(DIV_STEPS - 1);
          state_d     = S_DIV;
        end else begin
          cmd_o.blink_level = 1'b1;
          state_d           = S_MUL;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FLOOR;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_FLOOR: begin
        cmd_o.breathe_level = 1'b1;
        state_d             = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_OFF: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_off = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A finished result waits in its state while the output word is held
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && stat_i.out_busy) |=> state_q == S_OUT)
    else $error("result dropped while output stalled");

  // The modulo sweep runs for one step per time bit
  a_mod_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_mod |=> (state_q == S_MOD && cnt_q == CNT_W'(TIME_BITS - 1)))
    else $error("modulo sweep started with wrong count");

  // Only one of the two output loads at a time
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_out && cmd_o.load_off))
    else $error("two output loads at once");
`endif

endmodule

// ----- sv/slpg_dp.sv -----
`timescale 1ns / 1ps

module slpg_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slpg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [slpg_pkg::STATUS_W-1:0]  in_status_i,
  input  slpg_pkg::dp_cmd_t              cmd_i,
  output slpg_pkg::dp_stat_t             stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [slpg_pkg::COLOR_W-1:0]   out_red_o,
  output logic [slpg_pkg::COLOR_W-1:0]   out_green_o,
  output logic [slpg_pkg::COLOR_W-1:0]   out_blue_o,
  output logic [slpg_pkg::STATUS_W-1:0]  out_status_o
);
  import slpg_pkg::*;

  // State and configuration
  logic [TIME_BITS-1:0] time_q, last_q;
  logic [STATUS_W-1:0]  status_q;
  logic [CFG_W-1:0]     interval_q;
  logic                 out_valid_q;

  // Work registers
  logic [TIME_BITS-1:0] shift_q;
  logic [PERIOD_W-1:0]  rem_q;
  logic [NUM_W-1:0]     num_q;
  logic [COLOR_W-1:0]   quo_q;
  logic [COLOR_W-1:0]   lvl_q;
  logic [PROD_W-1:0]    prod_r_q, prod_g_q, prod_b_q;
  logic [COLOR_W-1:0]   red_q, green_q, blue_q;
  logic [STATUS_W-1:0]  shown_q;

  look_t                look;
  logic [HALF_W-1:0]    half;
  logic [TIME_BITS-1:0] elapsed;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    trial_sub;
  logic [HALF_W-1:0]    rising;
  logic [NUM_W-1:0]     div_cmp;

  assign look = look_of(status_q);
  assign half = look.period[PERIOD_W-1:1];

  // Refresh test on wrapped elapsed time
  assign elapsed            = time_q - last_q;
  assign stat_o.refresh_due = elapsed >= TIME_BITS'(interval_q);
  assign stat_o.breathe     = look.breathe;
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

  // One restoring step of time mod period
  assign trial     = {rem_q, shift_q[TIME_BITS-1]};
  assign trial_sub = trial - {1'b0, look.period};

  // Triangle position and shifted divisor for the quotient bit
  assign rising  = (rem_q < PERIOD_W'(half)) ? rem_q[HALF_W-1:0]
                                             : HALF_W'(look.period - rem_q);
  assign div_cmp = NUM_W'(half) << cmd_i.div_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      last_q      <= '0;
      status_q    <= ST_INIT;
      interval_q  <= INTERVAL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (cmd_i.tick) begin
        time_q <= time_q + TIME_BITS'(1);
      end
      if (cmd_i.start_mod) begin
        last_q <= time_q;
      end
      if (cmd_i.set_status) begin
        if (in_status_i inside {[ST_INIT:ST_CALIB]}) begin
          status_q <= in_status_i;
        end else begin
          status_q <= ST_INIT;
        end
      end
      if (cmd_i.load_out || cmd_i.load_off) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Iterative modulo, division and scaling
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_mod) begin
      shift_q <= time_q;
      rem_q   <= '0;
    end else if (cmd_i.mod_step) begin
      shift_q <= shift_q << 1;
      rem_q   <= trial_sub[PERIOD_W] ? trial[PERIOD_W-1:0] : trial_sub[PERIOD_W-1:0];
    end
    if (cmd_i.scale) begin
      num_q <= NUM_W'(rising) * NUM_W'(SPAN_LEVEL);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (num_q >= div_cmp) begin
        num_q                <= num_q - div_cmp;
        quo_q[cmd_i.div_bit] <= 1'b1;
      end
    end
    if (cmd_i.blink_level) begin
      lvl_q <= (rem_q < PERIOD_W'(half)) ? FULL_LEVEL : '0;
    end else if (cmd_i.breathe_level) begin
      lvl_q <= FLOOR_LEVEL + quo_q;
    end
    if (cmd_i.mul) begin
      prod_r_q <= PROD_W'(look.r) * PROD_W'(lvl_q);
      prod_g_q <= PROD_W'(look.g) * PROD_W'(lvl_q);
      prod_b_q <= PROD_W'(look.b) * PROD_W'(lvl_q);
    end
    if (cmd_i.load_out) begin
      red_q   <= div255(prod_r_q);
      green_q <= div255(prod_g_q);
      blue_q  <= div255(prod_b_q);
      shown_q <= status_q;
    end else if (cmd_i.load_off) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      shown_q <= status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = red_q;
  assign out_green_o  = green_q;
  assign out_blue_o   = blue_q;
  assign out_status_o = shown_q;

`ifndef NO_ASSERTIONS
  // A held output word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out || cmd_i.load_off) |-> !(out_valid_q && !out_ready_i))
    else $error("output word overwritten while stalled");

  // The running remainder stays below the period
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_step |=> rem_q < look.period)
    else $error("remainder out of range");

  // Breathing level never drops below the floor
  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.breathe_level |=> lvl_q >= FLOOR_LEVEL)
    else $error("breathing level below floor");

  // A refresh moves the refresh mark to the current time
  a_refresh_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_mod |=> last_q == time_q)
    else $error("refresh mark not updated");
`endif

endmodule

// ----- sv/status_led_pattern_generator.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    op, new_status
// out_o     out  valid/ready    red, green, blue, shown_status
// cfg       in   cfg_we_i       cfg_wdata_i (update interval, ms)
//
// One word is in work at a time. Set status and ignored ops are taken in idle;
// an off command loads a dark word. A tick runs the refresh test; on a refresh it
// runs the bit-serial time mod period, the level, for breathing the bit-serial
// ramp quotient and floor, then the multiply and, with the output free, the load.
// Reset (rst_ni, async low): time and refresh mark 0, status init, interval 20.
// A stalled output holds the last word; the block waits before loading another.

module status_led_pattern_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  slpg_in_if.sink                     in_i,
  slpg_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [slpg_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import slpg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  slpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Time base, pattern arithmetic and output register
  slpg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_status_i  (in_i.new_status),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_red_o    (out_o.red),
    .out_green_o  (out_o.green),
    .out_blue_o   (out_o.blue),
    .out_status_o (out_o.shown_status)
  );

endmodule

// ----- bench/status_led_pattern_generator_tb.sv -----
`timescale 1ns / 1ps

module status_led_pattern_generator_tb;
  import slpg_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 100;   // covers a refreshing tick
  localparam int HOLD_CYCLES   = 400;   // one long output back-pressure stretch
  localparam int PHASE_WORDS   = 75;
  localparam int WIDE_TICKS    = 40;    // ticks under the widest interval

  // One color word as seen on the output channel
  typedef struct packed {
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [STATUS_W-1:0] status;
  } led_word_t;

  // Tracks time, refresh mark, status and interval; queues predicted color words
  class led_scoreboard;
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] last_refresh;
    logic [STATUS_W-1:0]  status;
    logic [CFG_W-1:0]     interval;
    led_word_t            color_q[$];
    int                   errors;
    int                   words_in;
    int                   words_checked;
    int                   refreshes;

    function new();
      now_ms        = '0;
      last_refresh  = '0;
      status        = ST_INIT;
      interval      = INTERVAL_RESET;
      errors        = 0;
      words_in      = 0;
      words_checked = 0;
      refreshes     = 0;
    endfunction

    // Base color of the status scaled by the pattern level at time t
    function led_word_t scaled_color(logic [STATUS_W-1:0] st, logic [TIME_BITS-1:0] t);
      int unsigned base_r, base_g, base_b, period, phase, half, ramp, level;
      bit          breathe;
      led_word_t   w;
      case (st)
        ST_NORMAL: begin
          base_r = 0;   base_g = 255; base_b = 0;   period = 3000; breathe = 1'b1;
        end
        ST_WARN: begin
          base_r = 255; base_g = 140; base_b = 0;   period = 900;  breathe = 1'b0;
        end
        ST_ERROR: begin
          base_r = 255; base_g = 0;   base_b = 0;   period = 250;  breathe = 1'b0;
        end
        ST_CALIB: begin
          base_r = 255; base_g = 0;   base_b = 200; period = 500;  breathe = 1'b1;
        end
        default: begin
          base_r = 0;   base_g = 40;  base_b = 255; period = 600;  breathe = 1'b1;
        end
      endcase
      phase = t % period;
      half  = period / 2;
      if (!breathe) begin
        level = (phase < half) ? FULL_LEVEL : 0;
      end else begin
        // triangle: up over the first half, back down over the second
        ramp  = (phase < half) ? phase : period - phase;
        level = FLOOR_LEVEL + (ramp * SPAN_LEVEL) / half;
      end
      w.red    = COLOR_W'(base_r * level / FULL_LEVEL);
      w.green  = COLOR_W'(base_g * level / FULL_LEVEL);
      w.blue   = COLOR_W'(base_b * level / FULL_LEVEL);
      w.status = st;
      return w;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [STATUS_W-1:0] st);
      words_in++;
      case (op)
        OP_SET: status = (st <= ST_CALIB) ? st : ST_INIT;
        OP_OFF: color_q.push_back('{red: '0, green: '0, blue: '0, status: status});
        OP_TICK: begin
          now_ms++;
          if (now_ms - last_refresh >= interval) begin
            last_refresh = now_ms;
            refreshes++;
            color_q.push_back(scaled_color(status, now_ms));
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(led_word_t got);
      led_word_t want;
      if (color_q.size() == 0) begin
        report($sformatf("unexpected word r=%0d g=%0d b=%0d st=%0d",
                         got.red, got.green, got.blue, got.status));
        return;
      end
      want = color_q.pop_front();
      words_checked++;
      if (got.red !== want.red)
        report($sformatf("red got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d want %0d", got.blue, want.blue));
      if (got.status !== want.status)
        report($sformatf("shown_status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               no_stall;
  bit               hold_req;
  int               hold_left;
  int               ready_gap;
  int               idle_cycles;
  led_word_t        seen_word;
  led_scoreboard    sb;

  slpg_in_if  in_if ();
  slpg_out_if out_if ();

  status_led_pattern_generator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(25, 80);
  endfunction

  // Offer one word, wait for the handshake, then idle a random gap (none when no_stall)
  task automatic send_word(logic [OP_W-1:0] op, logic [STATUS_W-1:0] st);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.new_status <= st;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_input(op, st);
    gap = no_stall ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int               r;
    logic [OP_W-1:0] op;
    r  = $urandom_range(99);
    op = (r < 72) ? OP_TICK : (r < 85) ? OP_SET : (r < 97) ? OP_OFF : OP_UNUSED;
    send_word(op, STATUS_W'($urandom_range(7)));
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
  endtask

  // Block is idle once every color word is back and a refresh has had time to end
  task automatic wait_idle();
    while (sb.color_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.interval = value;
  endtask

  // Output ready: random gaps, plus one long hold on request
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    ready_gap    = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (ready_gap > 0) begin
        out_if.ready <= 1'b0;
        ready_gap--;
      end else begin
        out_if.ready <= 1'b1;
        ready_gap = no_stall ? 0 : pick_gap();
      end
    end
  end

  // Check every accepted color word
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen_word = '{red: out_if.red, green: out_if.green, blue: out_if.blue,
                    status: out_if.shown_status};
      sb.check_result(seen_word);
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int          waited;
    int unsigned intervals [6];
    in_if.valid      = 1'b0;
    in_if.op         = OP_TICK;
    in_if.new_status = ST_INIT;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    no_stall         = 1'b0;
    hold_req         = 1'b0;
    idle_cycles      = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: off before any status, a few ticks under the reset interval
    no_stall = 1'b1;
    send_word(OP_OFF, ST_ERROR);
    repeat (3) send_word(OP_TICK, STATUS_W'($urandom_range(7)));
    end_burst();

    // Interval zero: every tick refreshes; walk status codes 1 to 7 incl. out of range
    write_interval('0);
    for (int s = 1; s < 8; s++) begin
      send_word(OP_SET, STATUS_W'(s));
      send_word(OP_TICK, ~STATUS_W'(s));
    end
    send_word(OP_UNUSED, ST_WARN);
    send_word(OP_OFF, 3'd7);
    end_burst();
    no_stall = 1'b0;

    // Random phases over several refresh intervals
    intervals = '{1, 20, 0, $urandom_range(2, 40), 7, 2};
    foreach (intervals[p]) begin
      write_interval(CFG_W'(intervals[p]));
      no_stall = (p == 2);
      if (p == 0) hold_req = 1'b1;  // long back-pressure while words keep coming
      repeat (PHASE_WORDS) send_random();
      end_burst();
    end

    // Widest interval: a run of ticks that stays under it, then off
    write_interval('1);
    no_stall = 1'b1;
    repeat (WIDE_TICKS) send_word(OP_TICK, STATUS_W'($urandom_range(7)));
    send_word(OP_OFF, STATUS_W'($urandom_range(7)));
    end_burst();
    no_stall = 1'b0;

    // Drain, then flag anything still outstanding
    waited = 0;
    while (sb.color_q.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.color_q.size() != 0) begin
      void'(sb.color_q.pop_front());
      sb.report("expected color word never arrived");
    end

    $display("Covered %0d input words, %0d color words checked, %0d refreshes.",
             sb.words_in, sb.words_checked, sb.refreshes);
    $display("Intervals 0 to 1023, all status codes, off and unused ops, long output stall.");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/slpg_pkg.sv
sv/slpg_in_if.sv
sv/slpg_out_if.sv
sv/slpg_ctrl.sv
sv/slpg_dp.sv
sv/status_led_pattern_generator.sv
bench/status_led_pattern_generator_tb.sv
